/* src/tcw_pkg.sv */
package tcw_pkg;

    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 50;

    localparam int COL_W   = 7;
    localparam int ROW_W   = 6;
    localparam int IDX_W   = 12;
    localparam int VAL_W   = 64;
    localparam int CHAR_W  = 8;
    localparam int WORD_W  = 16;
    localparam int DIGIT_W = 4;
    localparam int OP_W    = 2;

    localparam int HEX_DIGITS = VAL_W / DIGIT_W;
    localparam int DEC_DIGITS = 20;
    localparam int BCD_W      = DEC_DIGITS * DIGIT_W;
    localparam int CNT_W      = 7;

    localparam logic [OP_W-1:0] OP_CHAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_HEX   = 2'd1;
    localparam logic [OP_W-1:0] OP_DEC   = 2'd2;
    localparam logic [OP_W-1:0] OP_PLACE = 2'd3;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        K_CHAR,
        K_HEX,
        K_DEC,
        K_MINUS,
        K_PLACE
    } t_emit_kind;

    typedef struct packed {
        logic       load;
        logic       conv;
        logic       skip;
        logic       emit;
        t_emit_kind kind;
        logic       last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic neg;
        logic place_ok;
        logic cnt_one;
        logic top_zero;
    } t_dp_stat;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dz;
        dz = CHAR_W'(d);
        if (d < 4'd10) begin
            return CH_ZERO + dz;
        end
        return CH_A + dz - CHAR_W'(10);
    endfunction

    function automatic logic [IDX_W-1:0] cell_idx(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
        logic [ROW_W+COL_W-1:0] full;
        full = (ROW_W+COL_W)'(row) * (ROW_W+COL_W)'(SCREEN_COLUMNS)
             + (ROW_W+COL_W)'(col);
        return full[IDX_W-1:0];
    endfunction

endpackage

/* src/tcw_dp.sv */
module tcw_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_text_color,
    input  logic [tcw_pkg::OP_W-1:0]      i_op,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_character,
    input  logic [tcw_pkg::VAL_W-1:0]     i_value,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_cell_color,
    input  logic [tcw_pkg::COL_W-1:0]     i_column_pos,
    input  logic [tcw_pkg::ROW_W-1:0]     i_row_pos,
    input  tcw_pkg::t_dp_cmd              i_cmd,
    output tcw_pkg::t_dp_stat             o_stat,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tcw_pkg::IDX_W-1:0]     o_cell_index,
    output logic [tcw_pkg::WORD_W-1:0]    o_cell_word,
    output logic                          o_last
);
    import tcw_pkg::*;

    logic [CHAR_W-1:0] r_color, n_color;
    logic [COL_W-1:0]  r_cur_col, n_cur_col;
    logic [ROW_W-1:0]  r_cur_row, n_cur_row;
    logic [CHAR_W-1:0] r_char, n_char;
    logic [CHAR_W-1:0] r_attr, n_attr;
    logic [COL_W-1:0]  r_pcol, n_pcol;
    logic [ROW_W-1:0]  r_prow, n_prow;
    logic [VAL_W-1:0]  r_work, n_work;
    logic [BCD_W-1:0]  r_bcd, n_bcd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [WORD_W-1:0] r_word, n_word;
    logic              r_last, n_last;

    logic [BCD_W-1:0]  adj;
    logic [CHAR_W-1:0] ch;
    logic              adv;

    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (r_bcd[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                adj[i*DIGIT_W +: DIGIT_W] = r_bcd[i*DIGIT_W +: DIGIT_W] + 4'd3;
            end else begin
                adj[i*DIGIT_W +: DIGIT_W] = r_bcd[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_comb begin
        n_color     = r_color;
        n_cur_col   = r_cur_col;
        n_cur_row   = r_cur_row;
        n_char      = r_char;
        n_attr      = r_attr;
        n_pcol      = r_pcol;
        n_prow      = r_prow;
        n_work      = r_work;
        n_bcd       = r_bcd;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid & i_out_stall;
        n_idx       = r_idx;
        n_word      = r_word;
        n_last      = r_last;
        ch          = r_char;
        adv         = 1'b0;

        if (i_cfg_valid) begin
            n_color = i_text_color;
        end

        if (i_cmd.load) begin
            n_char = i_character;
            n_attr = i_cell_color;
            n_pcol = i_column_pos;
            n_prow = i_row_pos;
            n_bcd  = '0;
            if (i_op == OP_DEC && i_value[VAL_W-1]) begin
                n_work = -i_value;
            end else begin
                n_work = i_value;
            end
            if (i_op == OP_HEX) begin
                n_cnt = CNT_W'(HEX_DIGITS);
            end else begin
                n_cnt = CNT_W'(VAL_W);
            end
        end

        if (i_cmd.conv) begin
            n_bcd  = {adj[BCD_W-2:0], r_work[VAL_W-1]};
            n_work = r_work << 1;
            if (r_cnt == CNT_W'(1)) begin
                n_cnt = CNT_W'(DEC_DIGITS);
            end else begin
                n_cnt = r_cnt - CNT_W'(1);
            end
        end

        if (i_cmd.skip) begin
            n_bcd = r_bcd << DIGIT_W;
            n_cnt = r_cnt - CNT_W'(1);
        end

        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_last      = i_cmd.last;
            adv         = 1'b1;
            case (i_cmd.kind)
                K_CHAR: begin
                    ch = r_char;
                end
                K_HEX: begin
                    ch     = hex_char(r_work[VAL_W-1 -: DIGIT_W]);
                    n_work = r_work << DIGIT_W;
                    n_cnt  = r_cnt - CNT_W'(1);
                end
                K_DEC: begin
                    ch    = CH_ZERO + CHAR_W'(r_bcd[BCD_W-1 -: DIGIT_W]);
                    n_bcd = r_bcd << DIGIT_W;
                    n_cnt = r_cnt - CNT_W'(1);
                end
                K_MINUS: begin
                    ch = CH_MINUS;
                end
                default: begin
                    ch  = r_char;
                    adv = 1'b0;
                end
            endcase
            if (adv) begin
                n_idx  = cell_idx(r_cur_row, r_cur_col);
                n_word = {r_color, ch};
                if (r_cur_col == COL_W'(SCREEN_COLUMNS - 1)) begin
                    n_cur_col = '0;
                    if (r_cur_row == ROW_W'(SCREEN_ROWS - 1)) begin
                        n_cur_row = '0;
                    end else begin
                        n_cur_row = r_cur_row + ROW_W'(1);
                    end
                end else begin
                    n_cur_col = r_cur_col + COL_W'(1);
                end
            end else begin
                n_idx  = cell_idx(r_prow, r_pcol);
                n_word = {r_attr, ch};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color     <= CHAR_W'(7);
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_color     <= n_color;
            r_cur_col   <= n_cur_col;
            r_cur_row   <= n_cur_row;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_char <= n_char;
        r_attr <= n_attr;
        r_pcol <= n_pcol;
        r_prow <= n_prow;
        r_work <= n_work;
        r_bcd  <= n_bcd;
        r_idx  <= n_idx;
        r_word <= n_word;
        r_last <= n_last;
    end

    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_stat.neg      = i_value[VAL_W-1];
    assign o_stat.place_ok = (i_column_pos < COL_W'(SCREEN_COLUMNS))
                          && (i_row_pos < ROW_W'(SCREEN_ROWS));
    assign o_stat.cnt_one  = (r_cnt == CNT_W'(1));
    assign o_stat.top_zero = (r_bcd[BCD_W-1 -: DIGIT_W] == '0);

    assign o_out_valid  = r_out_valid;
    assign o_cell_index = r_idx;
    assign o_cell_word  = r_word;
    assign o_last       = r_last;

endmodule

/* src/tcw_ctrl.sv */
module tcw_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [tcw_pkg::OP_W-1:0]  i_op,
    input  tcw_pkg::t_dp_stat         i_stat,
    output tcw_pkg::t_dp_cmd          o_cmd
);
    import tcw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHAR,
        S_PLACE,
        S_HEX,
        S_MINUS,
        S_CONV,
        S_SKIP,
        S_DEC
    } t_state;

    t_state  r_state, n_state;
    t_dp_cmd cmd;

    always_comb begin
        n_state  = r_state;
        cmd      = '0;
        cmd.kind = K_CHAR;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    unique case (i_op)
                        OP_CHAR:  n_state = S_CHAR;
                        OP_HEX:   n_state = S_HEX;
                        OP_DEC:   n_state = i_stat.neg ? S_MINUS : S_CONV;
                        default:  n_state = i_stat.place_ok ? S_PLACE : S_IDLE;
                    endcase
                end
            end
            S_CHAR: begin
                if (i_stat.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.kind = K_CHAR;
                    cmd.last = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_PLACE: begin
                if (i_stat.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.kind = K_PLACE;
                    cmd.last = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_HEX: begin
                if (i_stat.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.kind = K_HEX;
                    cmd.last = i_stat.cnt_one;
                    if (i_stat.cnt_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_MINUS: begin
                if (i_stat.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.kind = K_MINUS;
                    n_state  = S_CONV;
                end
            end
            S_CONV: begin
                cmd.conv = 1'b1;
                if (i_stat.cnt_one) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (i_stat.top_zero && !i_stat.cnt_one) begin
                    cmd.skip = 1'b1;
                end else begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (i_stat.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.kind = K_DEC;
                    cmd.last = i_stat.cnt_one;
                    if (i_stat.cnt_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd      = cmd;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> i_stat.out_free)
        else $error("cell write issued while output register is occupied");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.conv, cmd.skip, cmd.emit}))
        else $error("more than one datapath command in a cycle");

    a_conv_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV && i_stat.cnt_one) |=> (r_state == S_SKIP))
        else $error("conversion did not hand over to digit skip");

    a_hex_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load && i_op == OP_HEX) |=> (r_state == S_HEX && i_stat.cnt_one == 1'b0))
        else $error("hex transaction did not start with a full digit count");

endmodule

/* src/text_console_cell_writer_core.sv */
// Channel  | Direction | Handshake                  | Payload
// cfg      | in        | i_cfg_valid / o_cfg_ready  | i_text_color
// in       | in        | i_in_valid / o_in_stall    | i_op, i_character, i_value,
//          |           |                            | i_cell_color, i_column_pos, i_row_pos
// out      | out       | o_out_valid / i_out_stall  | o_cell_index, o_cell_word, o_last
//
// One transaction at a time; o_in_stall is high from acceptance to the last cell write.
// Char and place: 1 cell (none for an off-screen place). Hex: 16 cells.
// Decimal: shift-add-3 conversion over all 64 value bits, up to 19 leading-zero skips,
// a hand-over state, then up to 20 digit cells, after a minus cell if the value is negative.
// Synchronous active-low reset clears cursor, state and output valid, and sets text color to 7.
// A stall on the output holds the cell register and pauses the controller at its next cell write.
module text_console_cell_writer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_text_color,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tcw_pkg::OP_W-1:0]      i_op,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_character,
    input  logic [tcw_pkg::VAL_W-1:0]     i_value,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_cell_color,
    input  logic [tcw_pkg::COL_W-1:0]     i_column_pos,
    input  logic [tcw_pkg::ROW_W-1:0]     i_row_pos,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tcw_pkg::IDX_W-1:0]     o_cell_index,
    output logic [tcw_pkg::WORD_W-1:0]    o_cell_word,
    output logic                          o_last
);
    import tcw_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_op       (i_op),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tcw_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_text_color (i_text_color),
        .i_op         (i_op),
        .i_character  (i_character),
        .i_value      (i_value),
        .i_cell_color (i_cell_color),
        .i_column_pos (i_column_pos),
        .i_row_pos    (i_row_pos),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cell_index (o_cell_index),
        .o_cell_word  (o_cell_word),
        .o_last       (o_last)
    );

endmodule

/* tb/text_console_cell_writer_core_test.sv */
module text_console_cell_writer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int DEC_BASE      = 10;
    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 120;
    localparam int PHASE_ITEMS   = 60;
    localparam int NUM_PHASES    = 5;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] character;
        logic [VAL_W-1:0]  value;
        logic [CHAR_W-1:0] cell_color;
        logic [COL_W-1:0]  column_pos;
        logic [ROW_W-1:0]  row_pos;
    } console_cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [WORD_W-1:0] word;
        logic              last;
    } cell_write_t;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_cfg_valid  = 1'b0;
    logic               o_cfg_ready;
    logic [CHAR_W-1:0]  i_text_color = '0;
    logic               i_in_valid   = 1'b0;
    logic               o_in_stall;
    logic [OP_W-1:0]    i_op         = '0;
    logic [CHAR_W-1:0]  i_character  = '0;
    logic [VAL_W-1:0]   i_value      = '0;
    logic [CHAR_W-1:0]  i_cell_color = '0;
    logic [COL_W-1:0]   i_column_pos = '0;
    logic [ROW_W-1:0]   i_row_pos    = '0;
    logic               o_out_valid;
    logic               i_out_stall  = 1'b0;
    logic [IDX_W-1:0]   o_cell_index;
    logic [WORD_W-1:0]  o_cell_word;
    logic               o_last;

    console_cmd_t       pending_cmds[$];
    console_cmd_t       cmd_on_bus;
    bit                 cmd_taken   = 1'b0;
    int                 send_gap    = 0;
    int                 stall_left  = 0;
    bit                 calm        = 1'b0;
    int                 mismatches  = 0;

    logic [ROW_W-1:0]   cursor_row    = '0;
    logic [COL_W-1:0]   cursor_col    = '0;
    logic [CHAR_W-1:0]  console_color = 8'd7;
    cell_write_t        cell_q[$];

    text_console_cell_writer_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_text_color (i_text_color),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_character  (i_character),
        .i_value      (i_value),
        .i_cell_color (i_cell_color),
        .i_column_pos (i_column_pos),
        .i_row_pos    (i_row_pos),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cell_index (o_cell_index),
        .o_cell_word  (o_cell_word),
        .o_last       (o_last)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic cell_write_t make_cell(input int row, input int col,
                                              input logic [CHAR_W-1:0] ch,
                                              input logic [CHAR_W-1:0] attr);
        cell_write_t c;
        c.index = IDX_W'(row * SCREEN_COLUMNS + col);
        c.word  = {attr, ch};
        c.last  = 1'b0;
        return c;
    endfunction

    function automatic void cursor_write(input logic [CHAR_W-1:0] ch);
        cell_q.push_back(make_cell(cursor_row, cursor_col, ch, console_color));
        if (cursor_col == COL_W'(SCREEN_COLUMNS - 1)) begin
            cursor_col = '0;
            if (cursor_row == ROW_W'(SCREEN_ROWS - 1)) begin
                cursor_row = '0;
            end else begin
                cursor_row = cursor_row + ROW_W'(1);
            end
        end else begin
            cursor_col = cursor_col + COL_W'(1);
        end
    endfunction

    function automatic void predict_cells(input console_cmd_t cmd);
        logic [VAL_W-1:0]   mag;
        logic [DIGIT_W-1:0] nib;
        logic [DIGIT_W-1:0] digits[$];
        int                 produced;
        produced = 0;
        case (cmd.op)
            OP_CHAR: begin
                cursor_write(cmd.character);
                produced = 1;
            end
            OP_HEX: begin
                for (int i = HEX_DIGITS - 1; i >= 0; i--) begin
                    nib = cmd.value[i*DIGIT_W +: DIGIT_W];
                    if (nib < DEC_BASE) begin
                        cursor_write(CH_ZERO + CHAR_W'(nib));
                    end else begin
                        cursor_write(CH_A + CHAR_W'(nib) - CHAR_W'(DEC_BASE));
                    end
                end
                produced = HEX_DIGITS;
            end
            OP_DEC: begin
                mag = cmd.value;
                if (cmd.value[VAL_W-1]) begin
                    cursor_write(CH_MINUS);
                    produced++;
                    mag = -cmd.value;
                end
                do begin
                    digits.push_front(DIGIT_W'(mag % DEC_BASE));
                    mag = mag / DEC_BASE;
                end while (mag != 0);
                foreach (digits[k]) cursor_write(CH_ZERO + CHAR_W'(digits[k]));
                produced += digits.size();
            end
            default: begin
                if (cmd.column_pos < SCREEN_COLUMNS && cmd.row_pos < SCREEN_ROWS) begin
                    cell_q.push_back(make_cell(cmd.row_pos, cmd.column_pos,
                                               cmd.character, cmd.cell_color));
                    produced = 1;
                end
            end
        endcase
        if (produced > 0) begin
            cell_q[$].last = 1'b1;
        end
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        logic [VAL_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: v = v >> $urandom_range(0, VAL_W - 1);
            1: v = -(v >> $urandom_range(0, VAL_W - 1));
            default: ;
        endcase
        return v;
    endfunction

    function automatic console_cmd_t rand_cmd();
        console_cmd_t c;
        int           pick;
        c.character  = CHAR_W'($urandom);
        c.value      = rand_value();
        c.cell_color = CHAR_W'($urandom);
        c.column_pos = COL_W'($urandom);
        c.row_pos    = ROW_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            c.op = OP_CHAR;
        end else if (pick < 52) begin
            c.op = OP_HEX;
        end else if (pick < 87) begin
            c.op = OP_DEC;
        end else begin
            c.op = OP_PLACE;
            if ($urandom_range(0, 4) != 0) begin
                c.column_pos = COL_W'($urandom_range(0, SCREEN_COLUMNS - 1));
                c.row_pos    = ROW_W'($urandom_range(0, SCREEN_ROWS - 1));
            end
        end
        return c;
    endfunction

    function automatic bit cmd_writes(input console_cmd_t c);
        return c.op != OP_PLACE
            || (c.column_pos < SCREEN_COLUMNS && c.row_pos < SCREEN_ROWS);
    endfunction

    function automatic void queue_cmd(input logic [OP_W-1:0] op,
                                      input logic [CHAR_W-1:0] ch,
                                      input logic [VAL_W-1:0] value,
                                      input logic [CHAR_W-1:0] color,
                                      input logic [COL_W-1:0] col,
                                      input logic [ROW_W-1:0] row);
        console_cmd_t c;
        c = '{op, ch, value, color, col, row};
        pending_cmds.push_back(c);
    endfunction

    function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                        input logic [WORD_W-1:0] got);
        if (got !== want) begin
            $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic write_color(input logic [CHAR_W-1:0] color);
        @(negedge i_clk);
        i_cfg_valid  <= 1'b1;
        i_text_color <= color;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        console_color = color;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_cmds.size() != 0 || i_in_valid || cell_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // transaction accepted on the command channel
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            predict_cells(cmd_on_bus);
            cmd_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (calm) begin
            send_gap = 0;
        end
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || cmd_taken) begin
            cmd_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                cmd_on_bus = pending_cmds.pop_front();
                i_op         <= cmd_on_bus.op;
                i_character  <= cmd_on_bus.character;
                i_value      <= cmd_on_bus.value;
                i_cell_color <= cmd_on_bus.cell_color;
                i_column_pos <= cmd_on_bus.column_pos;
                i_row_pos    <= cmd_on_bus.row_pos;
                i_in_valid   <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(1, 19);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || calm) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cell_write_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (cell_q.size() == 0) begin
                $display("%0t unexpected cell write: expected none actual index %0d word %h last %0b",
                         $time, o_cell_index, o_cell_word, o_last);
                mismatches++;
            end else begin
                want = cell_q.pop_front();
                check_field("cell_index", WORD_W'(want.index), WORD_W'(o_cell_index));
                check_field("cell_word", want.word, o_cell_word);
                check_field("last", WORD_W'(want.last), WORD_W'(o_last));
            end
        end
    end

    initial begin
        #(10_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        logic [CHAR_W-1:0] colors[NUM_PHASES];
        console_cmd_t      c;
        int                made;

        colors[0] = 8'h00;
        colors[1] = 8'hFF;
        colors[2] = CHAR_W'($urandom);
        colors[3] = 8'h1E;
        colors[4] = CHAR_W'($urandom);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_cmd(OP_CHAR, 8'h00, '0, '0, '0, '0);
        queue_cmd(OP_CHAR, 8'hFF, '1, '1, '1, '1);
        queue_cmd(OP_CHAR, 8'h41, '0, '0, '0, '0);
        queue_cmd(OP_HEX, '0, 64'h0, '0, '0, '0);
        queue_cmd(OP_HEX, '0, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0, '0);
        queue_cmd(OP_HEX, '0, 64'h0123_4567_89AB_CDEF, '0, '0, '0);
        queue_cmd(OP_DEC, '0, 64'd0, '0, '0, '0);
        queue_cmd(OP_DEC, '0, 64'd1, '0, '0, '0);
        queue_cmd(OP_DEC, '0, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0, '0);
        queue_cmd(OP_DEC, '0, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0, '0);
        queue_cmd(OP_DEC, '0, 64'h8000_0000_0000_0000, '0, '0, '0);
        queue_cmd(OP_DEC, '0, 64'd10, '0, '0, '0);
        queue_cmd(OP_DEC, '0, 64'hFFFF_FFFF_FFFF_FFF6, '0, '0, '0);
        queue_cmd(OP_DEC, '0, 64'd18446744073709551615 >> 1, '0, '0, '0);
        queue_cmd(OP_PLACE, 8'hFF, '0, 8'h00, 7'd0, 6'd0);
        queue_cmd(OP_PLACE, 8'h00, '0, 8'hFF, 7'd79, 6'd49);
        queue_cmd(OP_PLACE, 8'h5A, '0, 8'h3C, 7'd80, 6'd0);
        queue_cmd(OP_PLACE, 8'h5A, '0, 8'h3C, 7'd0, 6'd50);
        queue_cmd(OP_PLACE, 8'h5A, '0, 8'h3C, 7'd127, 6'd63);
        queue_cmd(OP_PLACE, 8'h7E, '0, 8'h81, 7'd79, 6'd0);
        queue_cmd(OP_CHAR, 8'h7E, '0, '0, '0, '0);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == NUM_PHASES - 1) begin
                calm = 1'b1;
            end
            write_color(colors[p]);
            made = 0;
            while (made < PHASE_ITEMS) begin
                c = rand_cmd();
                pending_cmds.push_back(c);
                if (cmd_writes(c)) begin
                    made++;
                end
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* files.f */
src/tcw_pkg.sv
src/tcw_dp.sv
src/tcw_ctrl.sv
src/text_console_cell_writer_core.sv
tb/text_console_cell_writer_core_test.sv
